[hdl/lpre_pkg.sv]
`default_nettype none
package lpre_pkg;

  localparam int PENDING_BITS = 32;
  localparam int NUM_BITS     = 64;
  localparam int DEC_DIGITS   = 20;

  typedef enum logic [3:0] {
    CMD_TABLE   = 4'd0,
    CMD_SYMNAME = 4'd1,
    CMD_SYMVAL  = 4'd2,
    CMD_COLNAME = 4'd3,
    CMD_STRVAL  = 4'd4,
    CMD_BOOL    = 4'd5,
    CMD_INT     = 4'd6,
    CMD_AT      = 4'd7,
    CMD_ATNOW   = 4'd8,
    CMD_FLUSH   = 4'd9,
    CMD_EMPTY   = 4'd10
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_TEXT  = 2'd0,
    KIND_FLUSH = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    OS_CONNECTED = 3'd0,
    OS_TABLE     = 3'd1,
    OS_SYMBOL    = 3'd2,
    OS_COLUMN    = 3'd3,
    OS_MAYFLUSH  = 3'd4,
    OS_DEAD      = 3'd5
  } order_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_TABLE   = 3'd1,
    PH_SYMNAME = 3'd2,
    PH_SYMVAL  = 3'd3,
    PH_COLNAME = 3'd4,
    PH_VALUE   = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_PRE,
    SQ_NUM,
    SQ_POST
  } seq_t;

  typedef enum logic [1:0] {
    DC_IDLE,
    DC_CONV,
    DC_EMIT
  } dec_t;

  // digit stream from the decimal unit
  typedef struct packed {
    logic       dv;
    logic       dlast;
    logic [3:0] digit;
  } dec_stat_t;

  localparam logic [4:0] OP_TABLE = 5'd1;
  localparam logic [4:0] OP_SYM   = 5'd2;
  localparam logic [4:0] OP_COL   = 5'd4;
  localparam logic [4:0] OP_AT    = 5'd8;
  localparam logic [4:0] OP_FLUSH = 5'd16;

  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  function automatic logic [4:0] allowed(input logic [2:0] os);
    case (os)
      OS_CONNECTED: allowed = OP_TABLE;
      OS_TABLE:     allowed = OP_SYM | OP_COL;
      OS_SYMBOL:    allowed = OP_SYM | OP_COL | OP_AT;
      OS_COLUMN:    allowed = OP_COL | OP_AT;
      OS_MAYFLUSH:  allowed = OP_FLUSH | OP_TABLE;
      default:      allowed = 5'd0;
    endcase
  endfunction

  function automatic logic esc_plain(input logic [7:0] c);
    esc_plain = (c == CH_SP) || (c == CH_COMMA) || (c == CH_EQ) || (c == CH_NL) ||
                (c == CH_CR) || (c == CH_QUOTE) || (c == CH_BSL);
  endfunction

  function automatic logic esc_quoted(input logic [7:0] c);
    esc_quoted = (c == CH_NL) || (c == CH_CR) || (c == CH_QUOTE) || (c == CH_BSL);
  endfunction

endpackage
`default_nettype wire

[hdl/lpre_dec.sv]
`default_nettype none
// Bit-serial binary to decimal (shift and add-3), then digits out MSB first
// with leading zeros dropped.
module lpre_dec (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [lpre_pkg::NUM_BITS-1:0]  mag,
  input  wire logic                           take,
  output lpre_pkg::dec_stat_t                 stat
);

  localparam int BCD_BITS = 4 * lpre_pkg::DEC_DIGITS;

  lpre_pkg::dec_t state, state_next;
  logic [lpre_pkg::NUM_BITS-1:0] digit_work;
  logic [BCD_BITS-1:0]           bcd, bcd_adj;
  logic [$clog2(lpre_pkg::NUM_BITS)-1:0]     cnt;
  logic [$clog2(lpre_pkg::DEC_DIGITS+1)-1:0] dn;
  logic lead_zero;
  logic nz_seen;

  always_comb begin
    for (int i = 0; i < lpre_pkg::DEC_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  // zeros after the first significant digit are real digits
  assign lead_zero = (bcd[BCD_BITS-1 -: 4] == 4'd0) && (dn > 1) && !nz_seen;

  always_comb begin
    state_next = state;
    case (state)
      lpre_pkg::DC_IDLE: if (start) state_next = lpre_pkg::DC_CONV;
      lpre_pkg::DC_CONV: if (cnt == '1) state_next = lpre_pkg::DC_EMIT;
      lpre_pkg::DC_EMIT: if (!lead_zero && take && dn == 1) state_next = lpre_pkg::DC_IDLE;
      default:           state_next = lpre_pkg::DC_IDLE;
    endcase
  end

  always_comb begin
    stat.dv    = (state == lpre_pkg::DC_EMIT) && !lead_zero;
    stat.dlast = (dn == 1);
    stat.digit = bcd[BCD_BITS-1 -: 4];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lpre_pkg::DC_IDLE;
    end else begin
      state <= state_next;
    end
    case (state)
      lpre_pkg::DC_IDLE: begin
        if (start) begin
          digit_work <= mag;
          bcd        <= '0;
          cnt        <= '0;
          dn         <= ($clog2(lpre_pkg::DEC_DIGITS+1))'(lpre_pkg::DEC_DIGITS);
          nz_seen    <= 1'b0;
        end
      end
      lpre_pkg::DC_CONV: begin
        bcd        <= {bcd_adj[BCD_BITS-2:0], digit_work[lpre_pkg::NUM_BITS-1]};
        digit_work <= {digit_work[lpre_pkg::NUM_BITS-2:0], 1'b0};
        cnt        <= cnt + 1'b1;
      end
      lpre_pkg::DC_EMIT: begin
        if (lead_zero || take) begin
          bcd <= {bcd[BCD_BITS-5:0], 4'd0};
          dn  <= dn - 1'b1;
        end
        if (take) nz_seen <= 1'b1;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

[hdl/line_protocol_record_encoder.sv]
`default_nettype none
// channel | handshake           | word
// --------+---------------------+-----------------------------------------
// in      | in_valid / in_stall | command, data_byte, last, number
// out     | out_valid/out_stall | kind, out_byte, end_of_run, pending_bytes
//
// One result word per cycle while out is not stalled and no conversion is under way; a
// byte token puts out 0 to 4 words. int/at: bit-serial conversion (sign and space go out
// meanwhile), then 20 digit positions stepped through one by one (leading zeros too), then
// one suffix byte. in_stall is high until the last result sits in the output register;
// an out stall freezes the sequence. rst (synchronous) returns to expect-table.
module line_protocol_record_encoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  command,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last,
  input  wire logic signed [63:0] number,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       kind,
  output logic [7:0]       out_byte,
  output logic             end_of_run,
  output logic [31:0]      pending_bytes
);

  localparam logic [lpre_pkg::PENDING_BITS-1:0] CNT_MAX = '1;

  lpre_pkg::seq_t state, state_next;
  logic [2:0] order_state, token_phase;
  logic       first_byte_flag;
  logic [lpre_pkg::PENDING_BITS-1:0] pending_count;

  logic [7:0] q [4];
  logic [2:0] qn;
  logic [1:0] qkind;
  logic       has_num;
  logic [7:0] post_byte;

  // decode of the incoming word
  logic       ok;
  logic [2:0] os_n, ph_n;
  logic       fb_n;
  logic [7:0] pb [4];
  logic [2:0] pn;
  logic [1:0] pk;
  logic       pnum;
  logic [7:0] ppost;
  logic [63:0] mag;
  logic       idle, fresh, acc;

  logic       emit_v, emit_end, ld;
  logic [7:0] emit_byte;
  logic [1:0] emit_kind;
  lpre_pkg::dec_stat_t dstat;
  logic [63:0] pc64;

  assign idle  = token_phase == lpre_pkg::PH_IDLE;
  assign fresh = first_byte_flag;
  assign in_stall = state != lpre_pkg::SQ_IDLE;
  assign acc   = in_valid && !in_stall;
  assign mag   = number[63] ? (64'd0 - number) : number;

  always_comb begin
    ok    = (order_state < lpre_pkg::OS_DEAD);
    os_n  = order_state;
    ph_n  = token_phase;
    fb_n  = first_byte_flag;
    pn    = 3'd0;
    pk    = lpre_pkg::KIND_TEXT;
    pnum  = 1'b0;
    ppost = lpre_pkg::CH_NL;
    for (int i = 0; i < 4; i++) pb[i] = 8'd0;
    if (ok) begin
      case (command)
        lpre_pkg::CMD_TABLE: begin
          ok = idle ? |(lpre_pkg::allowed(order_state) & lpre_pkg::OP_TABLE)
                    : token_phase == lpre_pkg::PH_TABLE;
          ph_n = lpre_pkg::PH_TABLE;
          fb_n = 1'b0;
          if (lpre_pkg::esc_plain(data_byte)) begin pb[pn[1:0]] = lpre_pkg::CH_BSL; pn++; end
          pb[pn[1:0]] = data_byte; pn++;
          if (last) begin
            os_n = lpre_pkg::OS_TABLE;
            ph_n = lpre_pkg::PH_IDLE;
            fb_n = 1'b1;
          end
        end
        lpre_pkg::CMD_SYMNAME: begin
          ok = idle ? |(lpre_pkg::allowed(order_state) & lpre_pkg::OP_SYM)
                    : token_phase == lpre_pkg::PH_SYMNAME;
          if (idle) begin pb[pn[1:0]] = lpre_pkg::CH_COMMA; pn++; end
          ph_n = lpre_pkg::PH_SYMNAME;
          fb_n = 1'b0;
          if (lpre_pkg::esc_plain(data_byte)) begin pb[pn[1:0]] = lpre_pkg::CH_BSL; pn++; end
          pb[pn[1:0]] = data_byte; pn++;
          if (last) begin
            pb[pn[1:0]] = lpre_pkg::CH_EQ; pn++;
            ph_n = lpre_pkg::PH_SYMVAL;
            fb_n = 1'b1;
          end
        end
        lpre_pkg::CMD_SYMVAL: begin
          ok = token_phase == lpre_pkg::PH_SYMVAL;
          fb_n = 1'b0;
          if (lpre_pkg::esc_plain(data_byte)) begin pb[pn[1:0]] = lpre_pkg::CH_BSL; pn++; end
          pb[pn[1:0]] = data_byte; pn++;
          if (last) begin
            os_n = lpre_pkg::OS_SYMBOL;
            ph_n = lpre_pkg::PH_IDLE;
            fb_n = 1'b1;
          end
        end
        lpre_pkg::CMD_COLNAME: begin
          ok = idle ? |(lpre_pkg::allowed(order_state) & lpre_pkg::OP_COL)
                    : token_phase == lpre_pkg::PH_COLNAME;
          if (idle) begin
            pb[pn[1:0]] = |(lpre_pkg::allowed(order_state) & lpre_pkg::OP_SYM) ?
                          lpre_pkg::CH_SP : lpre_pkg::CH_COMMA;
            pn++;
          end
          ph_n = lpre_pkg::PH_COLNAME;
          fb_n = 1'b0;
          if (lpre_pkg::esc_plain(data_byte)) begin pb[pn[1:0]] = lpre_pkg::CH_BSL; pn++; end
          pb[pn[1:0]] = data_byte; pn++;
          if (last) begin
            pb[pn[1:0]] = lpre_pkg::CH_EQ; pn++;
            os_n = lpre_pkg::OS_COLUMN;
            ph_n = lpre_pkg::PH_VALUE;
            fb_n = 1'b1;
          end
        end
        lpre_pkg::CMD_STRVAL: begin
          ok = token_phase == lpre_pkg::PH_VALUE;
          if (fresh) begin pb[pn[1:0]] = lpre_pkg::CH_QUOTE; pn++; end
          fb_n = 1'b0;
          if (lpre_pkg::esc_quoted(data_byte)) begin pb[pn[1:0]] = lpre_pkg::CH_BSL; pn++; end
          pb[pn[1:0]] = data_byte; pn++;
          if (last) begin
            pb[pn[1:0]] = lpre_pkg::CH_QUOTE; pn++;
            ph_n = lpre_pkg::PH_IDLE;
            fb_n = 1'b1;
          end
        end
        lpre_pkg::CMD_BOOL: begin
          ok = token_phase == lpre_pkg::PH_VALUE && fresh;
          pb[0] = number[0] ? lpre_pkg::CH_T : lpre_pkg::CH_F;
          pn = 3'd1;
          ph_n = lpre_pkg::PH_IDLE;
          fb_n = 1'b1;
        end
        lpre_pkg::CMD_INT: begin
          ok = token_phase == lpre_pkg::PH_VALUE && fresh;
          if (number[63]) begin pb[0] = lpre_pkg::CH_MINUS; pn = 3'd1; end
          pnum  = 1'b1;
          ppost = lpre_pkg::CH_I;
          ph_n = lpre_pkg::PH_IDLE;
          fb_n = 1'b1;
        end
        lpre_pkg::CMD_EMPTY: begin
          ok = fresh && (token_phase == lpre_pkg::PH_SYMVAL ||
                         token_phase == lpre_pkg::PH_VALUE);
          if (token_phase == lpre_pkg::PH_SYMVAL) begin
            os_n = lpre_pkg::OS_SYMBOL;
          end else begin
            pb[0] = lpre_pkg::CH_QUOTE;
            pb[1] = lpre_pkg::CH_QUOTE;
            pn = 3'd2;
          end
          ph_n = lpre_pkg::PH_IDLE;
          fb_n = 1'b1;
        end
        lpre_pkg::CMD_AT: begin
          ok = idle && |(lpre_pkg::allowed(order_state) & lpre_pkg::OP_AT);
          pb[0] = lpre_pkg::CH_SP;
          pn = 3'd1;
          if (number[63]) begin pb[1] = lpre_pkg::CH_MINUS; pn = 3'd2; end
          pnum  = 1'b1;
          ppost = lpre_pkg::CH_NL;
          os_n = lpre_pkg::OS_MAYFLUSH;
        end
        lpre_pkg::CMD_ATNOW: begin
          ok = idle && |(lpre_pkg::allowed(order_state) & lpre_pkg::OP_AT);
          pb[0] = lpre_pkg::CH_NL;
          pn = 3'd1;
          os_n = lpre_pkg::OS_MAYFLUSH;
        end
        lpre_pkg::CMD_FLUSH: begin
          ok = idle && |(lpre_pkg::allowed(order_state) & lpre_pkg::OP_FLUSH);
          pk = lpre_pkg::KIND_FLUSH;
          pn = 3'd1;
          os_n = lpre_pkg::OS_CONNECTED;
        end
        default: ok = 1'b0;
      endcase
    end
    if (!ok) begin
      os_n = lpre_pkg::OS_DEAD;
      ph_n = lpre_pkg::PH_IDLE;
      fb_n = 1'b1;
      pk   = lpre_pkg::KIND_ERROR;
      pn   = 3'd1;
      pnum = 1'b0;
      for (int i = 0; i < 4; i++) pb[i] = 8'd0;
    end
  end

  lpre_dec u_dec (
    .clk   (clk),
    .rst   (rst),
    .start (acc && pnum),
    .mag   (mag),
    .take  (state == lpre_pkg::SQ_NUM && ld),
    .stat  (dstat)
  );

  always_comb begin
    emit_v    = 1'b0;
    emit_byte = 8'd0;
    emit_kind = lpre_pkg::KIND_TEXT;
    emit_end  = 1'b0;
    case (state)
      lpre_pkg::SQ_PRE: begin
        emit_v    = 1'b1;
        emit_byte = q[0];
        emit_kind = qkind;
        emit_end  = (qn == 3'd1) && !has_num;
      end
      lpre_pkg::SQ_NUM: begin
        emit_v    = dstat.dv;
        emit_byte = lpre_pkg::CH_ZERO + {4'd0, dstat.digit};
      end
      lpre_pkg::SQ_POST: begin
        emit_v    = 1'b1;
        emit_byte = post_byte;
        emit_end  = 1'b1;
      end
      default: ;
    endcase
  end

  assign ld = emit_v && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    case (state)
      lpre_pkg::SQ_IDLE: begin
        if (acc) begin
          if (pn != 3'd0) state_next = lpre_pkg::SQ_PRE;
          else if (pnum)  state_next = lpre_pkg::SQ_NUM;
        end
      end
      lpre_pkg::SQ_PRE: begin
        if (ld && qn == 3'd1) state_next = has_num ? lpre_pkg::SQ_NUM : lpre_pkg::SQ_IDLE;
      end
      lpre_pkg::SQ_NUM:  if (ld && dstat.dlast) state_next = lpre_pkg::SQ_POST;
      lpre_pkg::SQ_POST: if (ld) state_next = lpre_pkg::SQ_IDLE;
      default:           state_next = lpre_pkg::SQ_IDLE;
    endcase
  end

  assign pc64 = 64'(pending_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= lpre_pkg::SQ_IDLE;
      order_state     <= lpre_pkg::OS_CONNECTED;
      token_phase     <= lpre_pkg::PH_IDLE;
      first_byte_flag <= 1'b1;
      pending_count   <= '0;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (acc) begin
        order_state     <= os_n;
        token_phase     <= ph_n;
        first_byte_flag <= fb_n;
      end
      if (ld) begin
        out_valid <= 1'b1;
        if (emit_kind == lpre_pkg::KIND_FLUSH) begin
          pending_count <= '0;
        end else if (emit_kind == lpre_pkg::KIND_TEXT && pending_count != CNT_MAX) begin
          pending_count <= pending_count + 1'b1;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      for (int i = 0; i < 4; i++) q[i] <= pb[i];
      qn        <= pn;
      qkind     <= pk;
      has_num   <= pnum;
      post_byte <= ppost;
    end else if (state == lpre_pkg::SQ_PRE && ld) begin
      q[0] <= q[1];
      q[1] <= q[2];
      q[2] <= q[3];
      qn   <= qn - 1'b1;
    end
    if (ld) begin
      kind       <= emit_kind;
      out_byte   <= (emit_kind == lpre_pkg::KIND_TEXT) ? emit_byte : 8'd0;
      end_of_run <= emit_end;
      if (emit_kind == lpre_pkg::KIND_FLUSH) begin
        pending_bytes <= (|pc64[63:32]) ? 32'hFFFF_FFFF : pc64[31:0];
      end else begin
        pending_bytes <= 32'd0;
      end
    end
  end

endmodule
`default_nettype wire
